// ===== hw/rtl/bspid_pkg.sv =====
// Shared constants for the button setpoint PID speed controller.
package bspid_pkg;

   localparam int SPEED_BITS_DEF = 10;
   localparam int NUM_BUTTONS    = 5;
   localparam int GAIN_W         = 8;
   localparam int ILIM_W         = 10;
   localparam int DUTY_W         = 8;
   localparam int LED_W          = 8;
   localparam int CNT_W          = 2;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;

   localparam logic [CSR_INDEX_W-1:0] REG_P_GAIN         = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_I_GAIN         = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_D_GAIN         = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_INTEGRAL_LIMIT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SMALL_STEP     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_LARGE_STEP     = 3'd5;

   localparam logic [GAIN_W-1:0] P_GAIN_RST     = 8'd1;
   localparam logic [GAIN_W-1:0] I_GAIN_RST     = 8'd1;
   localparam logic [GAIN_W-1:0] D_GAIN_RST     = 8'd50;
   localparam logic [ILIM_W-1:0] ILIMIT_RST     = 10'd1023;
   localparam logic [GAIN_W-1:0] SMALL_STEP_RST = 8'd10;
   localparam logic [GAIN_W-1:0] LARGE_STEP_RST = 8'd50;
   localparam logic [LED_W-1:0]  LED_RST        = 8'hFF;

   // Menu state codes: odd = button held, even = button released
   localparam int MENU_W = 4;
   localparam logic [MENU_W-1:0] MENU_IDLE    = 4'd0;
   localparam logic [MENU_W-1:0] MENU_B1_HELD = 4'd1;
   localparam logic [MENU_W-1:0] MENU_B1_REL  = 4'd2;
   localparam logic [MENU_W-1:0] MENU_B2_HELD = 4'd3;
   localparam logic [MENU_W-1:0] MENU_B2_REL  = 4'd4;
   localparam logic [MENU_W-1:0] MENU_B3_HELD = 4'd5;
   localparam logic [MENU_W-1:0] MENU_B3_REL  = 4'd6;
   localparam logic [MENU_W-1:0] MENU_B4_HELD = 4'd7;
   localparam logic [MENU_W-1:0] MENU_B4_REL  = 4'd8;
   localparam logic [MENU_W-1:0] MENU_B5_HELD = 4'd9;
   localparam logic [MENU_W-1:0] MENU_B5_REL  = 4'd10;

   // x / 10 == (x * 0xCCCD) >> 19 for every x below 2**16
   localparam int              DIV10_MUL_W = 16;
   localparam logic [15:0]     DIV10_MUL   = 16'hCCCD;
   localparam int              DIV10_SHIFT = 19;

endpackage

// ===== hw/rtl/button_setpoint_pid_speed_controller.sv =====
// Top level of the button setpoint PID speed controller.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------------
//  req_    | in        | req_valid/req_stall | req_buttons_pressed, req_measured_speed
//  rsp_    | out       | rsp_valid/rsp_stall | rsp_duty_cycle, rsp_led_pattern, rsp_setpoint
//  csr_    | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// One control tick per transaction. The whole tick (debounce, menu, setpoint
// clamp, PID, duty scaling) is one combinational pass from the request ports
// into the result register, and a transaction can be accepted every cycle
// while req_stall is low. A skid register behind the result register takes
// one more transaction while the result is stalled; req_stall rises only
// when the skid register is full. csr_ready is always high. Synchronous
// active-high reset restores all gains and controller state.
module button_setpoint_pid_speed_controller
   #(
      parameter int SPEED_BITS = bspid_pkg::SPEED_BITS_DEF
   )
   (
      input  logic                               clock,
      input  logic                               reset,

      input  logic                               req_valid,
      output logic                               req_stall,
      input  logic [bspid_pkg::NUM_BUTTONS-1:0]  req_buttons_pressed,
      input  logic [SPEED_BITS-1:0]              req_measured_speed,

      output logic                               rsp_valid,
      input  logic                               rsp_stall,
      output logic [bspid_pkg::DUTY_W-1:0]       rsp_duty_cycle,
      output logic [bspid_pkg::LED_W-1:0]        rsp_led_pattern,
      output logic [SPEED_BITS-1:0]              rsp_setpoint,

      input  logic                               csr_valid,
      output logic                               csr_ready,
      input  logic [bspid_pkg::CSR_INDEX_W-1:0]  csr_index,
      input  logic [bspid_pkg::CSR_DATA_W-1:0]   csr_wdata
   );

   import bspid_pkg::*;

   // Width of the setpoint arithmetic: room for +/- one step and a sign
   localparam int DES_W = SPEED_BITS + 2;
   // Width of the integral sum before clamping
   localparam int ISUM_W = ((SPEED_BITS > ILIM_W) ? SPEED_BITS : ILIM_W) + 2;
   // Width of one gain product and of the PID sum
   localparam int PROD_W = SPEED_BITS + GAIN_W + 2;
   localparam int IPROD_W = GAIN_W + ILIM_W + 2;
   localparam int OSUM_W = PROD_W + 2;
   // Width of 255 * out
   localparam int SCL_W = SPEED_BITS + DUTY_W;
   localparam int DIVP_W = SPEED_BITS + DIV10_MUL_W;

   localparam logic [SPEED_BITS-1:0] SPEED_MAX = {SPEED_BITS{1'b1}};

   typedef struct packed {
      logic [DUTY_W-1:0]     duty;
      logic [LED_W-1:0]      led;
      logic [SPEED_BITS-1:0] setpoint;
   } rsp_type;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [GAIN_W-1:0] p_gain_ff, i_gain_ff, d_gain_ff;
   logic [ILIM_W-1:0] ilimit_ff;
   logic [GAIN_W-1:0] small_step_ff, large_step_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_gain_ff     <= P_GAIN_RST;
         i_gain_ff     <= I_GAIN_RST;
         d_gain_ff     <= D_GAIN_RST;
         ilimit_ff     <= ILIMIT_RST;
         small_step_ff <= SMALL_STEP_RST;
         large_step_ff <= LARGE_STEP_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_P_GAIN:         p_gain_ff     <= csr_wdata[GAIN_W-1:0];
            REG_I_GAIN:         i_gain_ff     <= csr_wdata[GAIN_W-1:0];
            REG_D_GAIN:         d_gain_ff     <= csr_wdata[GAIN_W-1:0];
            REG_INTEGRAL_LIMIT: ilimit_ff     <= csr_wdata[ILIM_W-1:0];
            REG_SMALL_STEP:     small_step_ff <= csr_wdata[GAIN_W-1:0];
            REG_LARGE_STEP:     large_step_ff <= csr_wdata[GAIN_W-1:0];
            default: ;  // drop writes to unmapped indexes
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Handshake
   // ---------------------------------------------------------------------
   logic    rsp_valid_ff, skid_valid_ff;
   rsp_type rsp_ff, skid_ff;
   logic    req_fire, rsp_fire;

   assign req_stall = skid_valid_ff;
   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = rsp_valid_ff && !rsp_stall;

   // ---------------------------------------------------------------------
   // Controller state
   // ---------------------------------------------------------------------
   logic [CNT_W-1:0]      cnt_ff [NUM_BUTTONS];
   logic [CNT_W-1:0]      cnt_in [NUM_BUTTONS];
   logic [NUM_BUTTONS-1:0] flags;
   logic [MENU_W-1:0]     menu_ff, menu_in;
   logic [MENU_W-1:0]     acted_ff, acted_in;
   logic [SPEED_BITS-1:0] target_ff, target_in;
   logic [ILIM_W-1:0]     integ_ff, integ_in;
   logic [SPEED_BITS-1:0] prev_meas_ff;
   logic [DUTY_W-1:0]     last_duty_ff, duty_in;
   logic [LED_W-1:0]      led_ff, led_in;

   // Debounce: count rises to 2 while held, falls to 1 while released
   always_comb begin
      for (int k = 0; k < NUM_BUTTONS; k++) begin
         cnt_in[k] = cnt_ff[k];
         if (req_buttons_pressed[k]) begin
            cnt_in[k] = (cnt_ff[k] < 2'd2) ? cnt_ff[k] + 2'd1 : 2'd2;
         end else if (cnt_ff[k] != 2'd1) begin
            cnt_in[k] = (cnt_ff[k] > 2'd1) ? cnt_ff[k] - 2'd1 : 2'd1;
         end
         flags[k] = (cnt_in[k] >= 2'd2);
      end
   end

   // Setpoint / 10 for the LED display
   logic [DIVP_W-1:0] div10_prod;
   logic [DIVP_W-1:0] div10_q;

   assign div10_prod = DIVP_W'(target_ff) * DIVP_W'(DIV10_MUL);
   assign div10_q    = div10_prod >> DIV10_SHIFT;

   // Menu state machine and setpoint step
   logic signed [DES_W-1:0] desired;

   always_comb begin
      menu_in  = menu_ff;
      acted_in = acted_ff;
      led_in   = (menu_ff != MENU_B5_HELD) ? ~last_duty_ff : led_ff;
      desired  = $signed({2'b00, target_ff});
      unique case (menu_ff) inside
         MENU_IDLE: begin
            acted_in = MENU_IDLE;
            // lowest button number wins
            for (int k = NUM_BUTTONS - 1; k >= 0; k--) begin
               if (flags[k]) begin
                  menu_in = MENU_W'(2 * k + 1);
               end
            end
         end
         MENU_B1_HELD, MENU_B2_HELD, MENU_B3_HELD, MENU_B4_HELD, MENU_B5_HELD: begin
            if (!flags[menu_ff[MENU_W-1:1]]) begin
               menu_in = menu_ff + MENU_W'(1);
            end else if (acted_ff != menu_ff) begin
               // act once per press
               acted_in = menu_ff;
               unique case (menu_ff)
                  MENU_B1_HELD: desired = desired - $signed(DES_W'(small_step_ff));
                  MENU_B2_HELD: desired = desired + $signed(DES_W'(small_step_ff));
                  MENU_B3_HELD: desired = desired - $signed(DES_W'(large_step_ff));
                  MENU_B4_HELD: desired = desired + $signed(DES_W'(large_step_ff));
                  MENU_B5_HELD: led_in  = ~div10_q[LED_W-1:0];
                  default: ;
               endcase
            end
         end
         default: menu_in = MENU_IDLE;
      endcase
   end

   // Clamp the setpoint to 0..SPEED_MAX
   always_comb begin
      if (desired[DES_W-1]) begin
         target_in = '0;
      end else if (|desired[DES_W-2:SPEED_BITS]) begin
         target_in = SPEED_MAX;
      end else begin
         target_in = desired[SPEED_BITS-1:0];
      end
   end

   // PID
   logic signed [SPEED_BITS:0]   err, dmeas;
   logic signed [ISUM_W-1:0]     isum;
   logic signed [PROD_W-1:0]     p_prod, d_prod;
   logic signed [IPROD_W-1:0]    i_prod;
   logic signed [OSUM_W-1:0]     osum;
   logic [SPEED_BITS-1:0]        out_val;
   logic [SCL_W-1:0]             scaled, dq;

   assign err   = $signed({1'b0, target_in}) - $signed({1'b0, req_measured_speed});
   assign dmeas = $signed({1'b0, prev_meas_ff}) - $signed({1'b0, req_measured_speed});
   assign isum  = $signed({{(ISUM_W - ILIM_W){1'b0}}, integ_ff})
                + $signed({{(ISUM_W - SPEED_BITS - 1){err[SPEED_BITS]}}, err});

   // Clamp the integral to 0..integral_limit
   always_comb begin
      if (isum[ISUM_W-1]) begin
         integ_in = '0;
      end else if (isum[ISUM_W-2:0] > (ISUM_W-1)'(ilimit_ff)) begin
         integ_in = ilimit_ff;
      end else begin
         integ_in = isum[ILIM_W-1:0];
      end
   end

   assign p_prod = $signed({1'b0, p_gain_ff}) * err;
   assign i_prod = $signed({1'b0, i_gain_ff}) * $signed({1'b0, integ_in});
   assign d_prod = $signed({1'b0, d_gain_ff}) * dmeas;
   assign osum   = OSUM_W'(p_prod) + OSUM_W'(i_prod) + OSUM_W'(d_prod);

   always_comb begin
      if (osum[OSUM_W-1]) begin
         out_val = '0;
      end else if (|osum[OSUM_W-2:SPEED_BITS]) begin
         out_val = SPEED_MAX;
      end else begin
         out_val = osum[SPEED_BITS-1:0];
      end
   end

   // duty = 255 * out / SPEED_MAX; divide by 2**n - 1 as (y + (y >> n) + 1) >> n
   assign scaled  = {out_val, {DUTY_W{1'b0}}} - SCL_W'(out_val);
   assign dq      = scaled + (scaled >> SPEED_BITS) + SCL_W'(1);
   assign duty_in = dq[SPEED_BITS +: DUTY_W];

   // Advance controller state on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_BUTTONS; k++) begin
            cnt_ff[k] <= 2'd1;
         end
         menu_ff      <= MENU_IDLE;
         acted_ff     <= MENU_IDLE;
         target_ff    <= '0;
         integ_ff     <= '0;
         prev_meas_ff <= '0;
         last_duty_ff <= '0;
         led_ff       <= LED_RST;
      end else if (req_fire) begin
         for (int k = 0; k < NUM_BUTTONS; k++) begin
            cnt_ff[k] <= cnt_in[k];
         end
         menu_ff      <= menu_in;
         acted_ff     <= acted_in;
         target_ff    <= target_in;
         integ_ff     <= integ_in;
         prev_meas_ff <= req_measured_speed;
         last_duty_ff <= duty_in;
         led_ff       <= led_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result and skid registers
   // ---------------------------------------------------------------------
   rsp_type rsp_new;

   assign rsp_new.duty     = duty_in;
   assign rsp_new.led      = led_in;
   assign rsp_new.setpoint = target_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // drain the skid entry first; no request is taken meanwhile
         if (rsp_fire) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (req_fire) begin
         if (!rsp_valid_ff || rsp_fire) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_fire) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_fire) begin
            rsp_ff <= skid_ff;
         end
      end else if (req_fire) begin
         if (!rsp_valid_ff || rsp_fire) begin
            rsp_ff <= rsp_new;
         end else begin
            skid_ff <= rsp_new;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_duty_cycle  = rsp_ff.duty;
   assign rsp_led_pattern = rsp_ff.led;
   assign rsp_setpoint    = rsp_ff.setpoint;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   logic cnt_range_ok;

   always_comb begin
      cnt_range_ok = 1'b1;
      for (int k = 0; k < NUM_BUTTONS; k++) begin
         if (cnt_ff[k] == 2'd0 || cnt_ff[k] == 2'd3) begin
            cnt_range_ok = 1'b0;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset) req_fire |=> rsp_valid)
      else $error("accepted transaction produced no result");

   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held without a result in front of it");

   assert property (@(posedge clock) disable iff (reset)
                    skid_valid_ff && rsp_stall |=> skid_valid_ff && $stable(skid_ff))
      else $error("skid entry lost while result stalled");

   assert property (@(posedge clock) disable iff (reset) cnt_range_ok)
      else $error("debounce count left the range 1..2");

endmodule

// ===== tb/tb_button_setpoint_pid_speed_controller.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the button setpoint PID speed controller.

module tb_button_setpoint_pid_speed_controller;
   import bspid_pkg::*;

   localparam int SPEED_W      = SPEED_BITS_DEF;
   localparam int SPEED_TOP    = (1 << SPEED_W) - 1;
   localparam int TICKS_PER_MIX = 75;

   // Register write order: index i of the register list
   localparam logic [CSR_INDEX_W-1:0] REG_ORDER [6] = '{
      REG_P_GAIN, REG_I_GAIN, REG_D_GAIN, REG_INTEGRAL_LIMIT, REG_SMALL_STEP, REG_LARGE_STEP
   };

   typedef struct {
      logic [DUTY_W-1:0]  duty;
      logic [LED_W-1:0]   led;
      logic [SPEED_W-1:0] setpoint;
   } tick_result_type;

   // Controller predictor plus the queue of results it still owes the block.
   class pid_tick_scoreboard_type;
      logic [GAIN_W-1:0]      p_gain, i_gain, d_gain, small_step, large_step;
      logic [ILIM_W-1:0]      integral_limit;
      logic [CNT_W-1:0]       press_count [NUM_BUTTONS];
      logic [NUM_BUTTONS-1:0] held;
      logic [MENU_W-1:0]      menu, acted_menu;
      logic [SPEED_W-1:0]     target, prev_speed;
      logic [DUTY_W-1:0]      prev_duty;
      logic [LED_W-1:0]       led_reg;
      int                     integral;
      tick_result_type        owed_q [$];
      int                     failures, reports, ticks, steps;

      function new();
         p_gain         = P_GAIN_RST;
         i_gain         = I_GAIN_RST;
         d_gain         = D_GAIN_RST;
         integral_limit = ILIMIT_RST;
         small_step     = SMALL_STEP_RST;
         large_step     = LARGE_STEP_RST;
         foreach (press_count[k]) press_count[k] = 2'd1;
         held       = '0;
         menu       = MENU_IDLE;
         acted_menu = MENU_IDLE;
         target     = '0;
         prev_speed = '0;
         prev_duty  = '0;
         led_reg    = LED_RST;
         integral   = 0;
         failures   = 0;
         reports    = 0;
         ticks      = 0;
         steps      = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_P_GAIN:         p_gain         = data[GAIN_W-1:0];
            REG_I_GAIN:         i_gain         = data[GAIN_W-1:0];
            REG_D_GAIN:         d_gain         = data[GAIN_W-1:0];
            REG_INTEGRAL_LIMIT: integral_limit = data[ILIM_W-1:0];
            REG_SMALL_STEP:     small_step     = data[GAIN_W-1:0];
            REG_LARGE_STEP:     large_step     = data[GAIN_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_tick(logic [NUM_BUTTONS-1:0] raw, logic [SPEED_W-1:0] speed);
         int              desired, err, drive, btn, k;
         tick_result_type r;
         desired = int'(target);

         for (k = 0; k < NUM_BUTTONS; k++) begin
            if (raw[k])
               press_count[k] = (press_count[k] < 2) ? press_count[k] + 2'd1 : 2'd2;
            else if (press_count[k] > 1)
               press_count[k] = press_count[k] - 2'd1;
            else
               press_count[k] = 2'd1;
            held[k] = (press_count[k] >= 2);
         end

         if (menu != MENU_B5_HELD)
            led_reg = ~prev_duty;

         if (menu == MENU_IDLE) begin
            acted_menu = MENU_IDLE;
            for (k = NUM_BUTTONS - 1; k >= 0; k--)
               if (held[k]) menu = MENU_W'(MENU_B1_HELD + 2 * k);
         end else if (menu <= MENU_B5_REL && menu[0]) begin
            btn = (menu - MENU_B1_HELD) / 2;
            if (!held[btn]) begin
               menu = menu + 1'b1;
            end else if (acted_menu != menu) begin
               acted_menu = menu;
               steps++;
               case (menu)
                  MENU_B1_HELD: desired -= int'(small_step);
                  MENU_B2_HELD: desired += int'(small_step);
                  MENU_B3_HELD: desired -= int'(large_step);
                  MENU_B4_HELD: desired += int'(large_step);
                  default:      led_reg = ~LED_W'(desired / 10);
               endcase
            end
         end else begin
            menu = MENU_IDLE;
         end

         if (desired > SPEED_TOP) desired = SPEED_TOP;
         if (desired < 0) desired = 0;
         target = SPEED_W'(desired);

         err = int'(target) - int'(speed);
         integral += err;
         if (integral > int'(integral_limit))
            integral = int'(integral_limit);
         else if (integral < 0)
            integral = 0;

         drive = int'(p_gain) * err + int'(i_gain) * integral
               + int'(d_gain) * (int'(prev_speed) - int'(speed));
         prev_speed = speed;
         if (drive < 0)
            drive = 0;
         else if (drive > SPEED_TOP)
            drive = SPEED_TOP;
         prev_duty = DUTY_W'((255 * drive) / SPEED_TOP);

         r.duty     = prev_duty;
         r.led      = led_reg;
         r.setpoint = target;
         owed_q.push_back(r);
         ticks++;
      endfunction

      function void compare(string field, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            failures++;
            if (reports < 10) begin
               reports++;
               $display("%t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            end
         end
      endfunction

      function void check_result(logic [DUTY_W-1:0] duty, logic [LED_W-1:0] led,
                                 logic [SPEED_W-1:0] setpoint);
         tick_result_type want;
         if (owed_q.size() == 0) begin
            failures++;
            if (reports < 10) begin
               reports++;
               $display("%t: unexpected result, duty %0d led %0d setpoint %0d",
                        $time, duty, led, setpoint);
            end
            return;
         end
         want = owed_q.pop_front();
         compare("duty_cycle", want.duty, duty);
         compare("led_pattern", want.led, led);
         compare("setpoint", want.setpoint, setpoint);
      endfunction
   endclass

   logic                     clock;
   logic                     reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [NUM_BUTTONS-1:0]   req_buttons_pressed = '0;
   logic [SPEED_W-1:0]       req_measured_speed  = '0;

   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [DUTY_W-1:0]        rsp_duty_cycle;
   logic [LED_W-1:0]         rsp_led_pattern;
   logic [SPEED_W-1:0]       rsp_setpoint;

   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;

   // Percentages of cycles in which the sender idles and the receiver stalls
   int gap_pct    = 0;
   int stall_pct  = 0;
   int ticks_sent = 0;
   int settings   = 0;

   pid_tick_scoreboard_type sb = new();

   button_setpoint_pid_speed_controller #(.SPEED_BITS(SPEED_W)) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_buttons_pressed (req_buttons_pressed),
      .req_measured_speed  (req_measured_speed),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_duty_cycle      (rsp_duty_cycle),
      .rsp_led_pattern     (rsp_led_pattern),
      .rsp_setpoint        (rsp_setpoint),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Receiver side: stall at random according to the current mix
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Check every result transaction against the oldest prediction. Sampling at
   // the edge sees the values that were settled before it.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         sb.check_result(rsp_duty_cycle, rsp_led_pattern, rsp_setpoint);
   end

   // Pick a measured speed: anywhere, at an extreme, or close to the setpoint
   // so the PID works in its linear range and the integral moves both ways.
   function automatic logic [SPEED_W-1:0] pick_speed();
      int s;
      case ($urandom_range(3))
         0:       s = $urandom_range(SPEED_TOP);
         1:       s = $urandom_range(1) ? SPEED_TOP : 0;
         default: s = int'(sb.target) + int'($urandom_range(60)) - 30;
      endcase
      if (s < 0) s = 0;
      if (s > SPEED_TOP) s = SPEED_TOP;
      return SPEED_W'(s);
   endfunction

   // Offer one control tick; hold the payload until the block takes it, then
   // predict its result. Valid is only lowered for a random gap.
   task automatic send_tick(input logic [NUM_BUTTONS-1:0] buttons,
                            input logic [SPEED_W-1:0] speed);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_buttons_pressed <= buttons;
      req_measured_speed  <= speed;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_tick(buttons, speed);
      ticks_sent++;
   endtask

   // Hold a button pattern for some ticks, then release everything.
   task automatic press(input logic [NUM_BUTTONS-1:0] mask, input int hold_ticks,
                        input int rel_ticks);
      repeat (hold_ticks) send_tick(mask, pick_speed());
      repeat (rel_ticks) send_tick('0, pick_speed());
   endtask

   // Stop sending and wait until every predicted result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.owed_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Write all six registers back to back; valid stays high across them.
   task automatic load_registers(input logic [CSR_DATA_W-1:0] vals [6]);
      for (int i = 0; i < 6; i++) begin
         csr_valid <= 1'b1;
         csr_index <= REG_ORDER[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         sb.write_reg(REG_ORDER[i], vals[i]);
      end
      csr_valid <= 1'b0;
      settings++;
   endtask

   // Mostly clean presses (held long enough to act, then released so the menu
   // returns to idle), sometimes with lower-priority buttons held along;
   // the rest is raw noise on all five inputs.
   task automatic random_ticks(input int quota);
      int                     first;
      int                     btn;
      logic [NUM_BUTTONS-1:0] mask;
      first = ticks_sent;
      while (ticks_sent - first < quota) begin
         if ($urandom_range(99) < 75) begin
            btn  = $urandom_range(NUM_BUTTONS - 1);
            mask = NUM_BUTTONS'(1) << btn;
            if ($urandom_range(3) == 0)
               mask |= NUM_BUTTONS'($urandom) & ~((mask << 1) - 1'b1);
            press(mask, $urandom_range(1, 5), $urandom_range(1, 3));
         end else begin
            repeat ($urandom_range(1, 4)) send_tick(NUM_BUTTONS'($urandom), pick_speed());
         end
      end
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] vals [6];

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed ticks under reset gains, no idling. All buttons at once must
      // pick button 1, which tries to lower the setpoint below zero.
      send_tick(5'b11111, '0);
      send_tick(5'b11111, SPEED_W'(SPEED_TOP));
      send_tick(5'b00000, '0);
      send_tick(5'b00000, SPEED_W'(SPEED_TOP));
      // One press per button; button 2 is held an extra tick to show that a
      // held button acts only once, button 5 shows the setpoint on the LEDs.
      press(5'b01000, 2, 2);
      press(5'b00010, 3, 2);
      press(5'b10000, 2, 2);
      press(5'b00001, 2, 2);
      press(5'b00100, 2, 2);
      random_ticks(TICKS_PER_MIX);

      for (int setting = 1; setting <= 5; setting++) begin
         drain();
         case (setting)
            1: vals = '{255, 255, 255, 1023, 255, 255};
            2: vals = '{0, 0, 0, 0, 0, 0};
            3: vals = '{2, 1, 3, 100, 1, 7};
            default: begin
               foreach (vals[i])
                  vals[i] = (REG_ORDER[i] == REG_INTEGRAL_LIMIT) ?
                            CSR_DATA_W'($urandom_range(1023)) :
                            CSR_DATA_W'($urandom_range(255));
            end
         endcase
         // Rotate the idle mix: sender gaps, receiver stalls, both, none
         case (setting % 4)
            1: begin gap_pct = 52; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 52; end
            3: begin gap_pct = 36; stall_pct = 36; end
            default: begin gap_pct = 0; stall_pct = 0; end
         endcase
         load_registers(vals);
         random_ticks(TICKS_PER_MIX);
      end

      drain();
      repeat (8) @(posedge clock);

      $display("Covered %0d control ticks over %0d register settings and four idle mixes;",
               sb.ticks, settings + 1);
      $display("%0d button actions moved the setpoint or the LED readout, %0d mismatches.",
               sb.steps, sb.failures);
      if (sb.failures == 0 && sb.owed_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("Timeout with %0d results outstanding", sb.owed_q.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
